// File: hw/rtl/ahfc_pkg.sv
// ----------------------------------------------------------------------------
// ahfc_pkg
// shared types, codes and helpers for the ascii hex frame checker
// ----------------------------------------------------------------------------
package ahfc_pkg;

  localparam int unsigned POS_W  = 13;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 8;

  // header char positions run from one to this value
  localparam logic [POS_W-1:0] HDR_LAST_POS = 13'd12;
  // first info char position
  localparam logic [POS_W-1:0] INFO_POS     = 13'd13;
  // info chars plus four checksum chars
  localparam logic [POS_W-1:0] CSUM_END_OFS = 13'd17;
  localparam logic [POS_W-1:0] CSUM_LST_OFS = 13'd16;

  localparam logic [2:0] HDR_VERSION = 3'd0;
  localparam logic [2:0] HDR_LEN_LO  = 3'd5;

  localparam logic [CFG_AW-1:0] CFG_START_CHAR     = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_END_CHAR       = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_VERSION_FIRST  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_VERSION_SECOND = 2'd3;

  localparam logic [7:0] START_CHAR_RST     = 8'd126;
  localparam logic [7:0] END_CHAR_RST       = 8'd13;
  localparam logic [7:0] VERSION_FIRST_RST  = 8'd32;
  localparam logic [7:0] VERSION_SECOND_RST = 8'd33;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_START     = 3'd1,
    ST_VERSION   = 3'd2,
    ST_LEN_CHECK = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_END       = 3'd5,
    ST_TRUNCATED = 3'd6,
    ST_BAD_HEX   = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_last;
  } ahfc_in_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       device_address;
    logic [7:0]       command_one;
    logic [7:0]       command_two;
    logic [LEN_W-1:0] info_length;
  } ahfc_out_t;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] end_char;
    logic [7:0] version_first;
    logic [7:0] version_second;
  } ahfc_cfg_t;

  // returns {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ahfc_in_stage.sv
// ----------------------------------------------------------------------------
// ahfc_in_stage
// input register holding one received item
// ----------------------------------------------------------------------------
module ahfc_in_stage import ahfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ahfc_in_t in_data,
  input  logic     take,
  output logic     q_valid,
  output ahfc_in_t q_data
);

  logic     valid_r, valid_nxt;
  ahfc_in_t data_r;
  logic     load;

  // hold while the held item cannot move on
  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign q_valid = valid_r;
  assign q_data  = data_r;

endmodule

// File: hw/rtl/ahfc_frame_core.sv
// ----------------------------------------------------------------------------
// ahfc_frame_core
// per-frame state and the checks for one char
// ----------------------------------------------------------------------------
module ahfc_frame_core import ahfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ahfc_cfg_t cfg,
  input  logic      fire,
  input  ahfc_in_t  item,
  output ahfc_out_t res
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_upd;
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_upd;
  logic [3:0]       pend_r, pend_nxt, pend_upd;
  logic [7:0]       hdr_r   [6];
  logic [7:0]       hdr_nxt [6];
  logic [7:0]       hdr_upd [6];
  logic [SUM_W-1:0] rsum_r, rsum_nxt, rsum_upd;
  status_t          err_r, err_nxt, err_upd;
  logic             closed_r, closed_nxt, closed_upd;

  logic [4:0]       hx;
  logic [2:0]       idx;
  logic [7:0]       val;
  logic [3:0]       lsum;
  logic [LEN_W-1:0] dl;
  logic [POS_W-1:0] info_end, csum_end, csum_last;
  logic [7:0]       b;

  assign b         = item.rx_byte;
  assign hx        = hex_decode(b);
  assign idx       = pos_r[3:1] - 3'd1;
  assign val       = {pend_r, hx[3:0]};
  // length nibbles summed mod 16
  assign lsum      = hdr_r[4][3:0] + val[7:4] + val[3:0];
  assign dl        = {hdr_r[4][3:0], hdr_r[5]};
  assign info_end  = POS_W'(dl) + INFO_POS;
  assign csum_end  = POS_W'(dl) + CSUM_END_OFS;
  assign csum_last = POS_W'(dl) + CSUM_LST_OFS;

  always_comb begin
    pos_upd    = pos_r;
    sum_upd    = sum_r;
    pend_upd   = pend_r;
    rsum_upd   = rsum_r;
    err_upd    = err_r;
    closed_upd = closed_r;
    for (int i = 0; i < 6; i++) begin
      hdr_upd[i] = hdr_r[i];
    end

    if (!closed_r && err_r == ST_OK) begin
      pos_upd = pos_r + 13'd1;
      if (pos_r == '0) begin
        if (b != cfg.start_char) begin
          err_upd = ST_START;
        end
      end else if (pos_r <= HDR_LAST_POS) begin
        sum_upd = sum_r + SUM_W'(b);
        if (!hx[4]) begin
          err_upd = ST_BAD_HEX;
        end else if (pos_r[0]) begin
          pend_upd = hx[3:0];
        end else begin
          hdr_upd[idx] = val;
          if (idx == HDR_VERSION && val != cfg.version_first
              && val != cfg.version_second) begin
            err_upd = ST_VERSION;
          end
          if (idx == HDR_LEN_LO && hdr_r[4][7:4] != 4'(4'd0 - lsum)) begin
            err_upd = ST_LEN_CHECK;
          end
        end
      end else if (pos_r < info_end) begin
        sum_upd = sum_r + SUM_W'(b);
      end else if (pos_r < csum_end) begin
        if (!hx[4]) begin
          err_upd = ST_BAD_HEX;
        end else begin
          rsum_upd = {rsum_r[SUM_W-5:0], hx[3:0]};
          if (pos_r == csum_last && SUM_W'(16'd0 - sum_r) != rsum_upd) begin
            err_upd = ST_CHECKSUM;
          end
        end
      end else begin
        if (b != cfg.end_char) begin
          err_upd = ST_END;
        end else begin
          closed_upd = 1'b1;
        end
      end
    end
  end

  // the frame's last byte clears everything for the next frame
  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    pend_nxt   = pend_r;
    rsum_nxt   = rsum_r;
    err_nxt    = err_r;
    closed_nxt = closed_r;
    for (int i = 0; i < 6; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    if (fire) begin
      if (item.frame_last) begin
        pos_nxt    = '0;
        sum_nxt    = '0;
        pend_nxt   = '0;
        rsum_nxt   = '0;
        err_nxt    = ST_OK;
        closed_nxt = 1'b0;
        for (int i = 0; i < 6; i++) begin
          hdr_nxt[i] = '0;
        end
      end else begin
        pos_nxt    = pos_upd;
        sum_nxt    = sum_upd;
        pend_nxt   = pend_upd;
        rsum_nxt   = rsum_upd;
        err_nxt    = err_upd;
        closed_nxt = closed_upd;
        for (int i = 0; i < 6; i++) begin
          hdr_nxt[i] = hdr_upd[i];
        end
      end
    end
  end

  always_comb begin
    if (err_upd != ST_OK) begin
      res.status = err_upd;
    end else if (!closed_upd) begin
      res.status = ST_TRUNCATED;
    end else begin
      res.status = ST_OK;
    end
    res.device_address = hdr_upd[1];
    res.command_one    = hdr_upd[2];
    res.command_two    = hdr_upd[3];
    res.info_length    = {hdr_upd[4][3:0], hdr_upd[5]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      pend_r   <= '0;
      rsum_r   <= '0;
      err_r    <= ST_OK;
      closed_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      pend_r   <= pend_nxt;
      rsum_r   <= rsum_nxt;
      err_r    <= err_nxt;
      closed_r <= closed_nxt;
      for (int i = 0; i < 6; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

endmodule

// File: hw/rtl/ahfc_out_stage.sv
// ----------------------------------------------------------------------------
// ahfc_out_stage
// result register toward the consumer
// ----------------------------------------------------------------------------
module ahfc_out_stage import ahfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  ahfc_out_t res,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output ahfc_out_t out_data
);

  logic      valid_r, valid_nxt;
  ahfc_out_t data_r;

  // full and not drained this cycle
  assign busy      = valid_r && out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hw/rtl/ascii_hex_frame_checker.sv
// ----------------------------------------------------------------------------
// ascii_hex_frame_checker
// checks ascii hex telemetry frames one received byte at a time
// ----------------------------------------------------------------------------
// Takes one byte item per clock and gives one status item on each byte
// marked frame_last: the first error found in the frame (start, version,
// length check, checksum, end char, bad hex) or truncated, together with
// the decoded address, CID1, CID2 and info length. A byte is latched in the
// input register, checked against the frame state in one pass of logic and
// its status lands in the output register. Sustained rate is one byte per
// cycle; the only back pressure comes from the output register: a
// frame_last byte waits while an earlier status is still held by out_stall.
// Config writes take effect the next cycle and are meant for idle periods;
// there is no clearing pass after reset.
module ascii_hex_frame_checker import ahfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ahfc_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ahfc_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  ahfc_cfg_t cfg_r, cfg_nxt;
  logic      q_valid;
  ahfc_in_t  q_data;
  logic      out_busy;
  logic      take;
  ahfc_out_t res;

  // config registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_START_CHAR:     cfg_nxt.start_char     = cfg_wdata;
        CFG_END_CHAR:       cfg_nxt.end_char       = cfg_wdata;
        CFG_VERSION_FIRST:  cfg_nxt.version_first  = cfg_wdata;
        CFG_VERSION_SECOND: cfg_nxt.version_second = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_char     <= START_CHAR_RST;
      cfg_r.end_char       <= END_CHAR_RST;
      cfg_r.version_first  <= VERSION_FIRST_RST;
      cfg_r.version_second <= VERSION_SECOND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a byte that gives no status always moves on; a last byte needs room
  assign take = q_valid && (!q_data.frame_last || !out_busy);

  ahfc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  ahfc_frame_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (take),
    .item  (q_data),
    .res   (res)
  );

  ahfc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && q_data.frame_last),
    .res       (res),
    .busy      (out_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/ahfc_checker.sv
// ----------------------------------------------------------------------------
// ahfc_checker
// port level checks for the frame checker, bound to the top level
// ----------------------------------------------------------------------------
module ahfc_checker import ahfc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ahfc_in_t          in_data,
  input logic              out_valid,
  input logic              out_stall,
  input ahfc_out_t         out_data
);

  // a held status stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("status item changed while stalled");

  // input back pressure only comes from a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back pressure");

  // reset empties both registers
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // a new status needs an accepted byte marked last
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.frame_last, 2)
      || $past(in_stall, 1))
    else $error("status item without a final byte");

endmodule

bind ascii_hex_frame_checker ahfc_checker u_ahfc_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ascii hex frame checker
// ----------------------------------------------------------------------------
// Feeds received bytes into the checker and predicts the status of every frame
// with an independent frame decoder. Stimulus starts with a handful of
// directed frames and bytes, then goes through randomized phases. Each phase
// sets the four registers (the extremes included) and mixes good frames,
// frames with one injected flaw, truncated frames and random noise. Sender
// gaps and receiver stalls vary per phase, and one phase holds the result
// side off long enough to back up the input. Every status item is compared
// field by field, in order, against the predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import ahfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PHASE_BYTES     = 80;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 240;

  // kinds of damage done to a generated frame
  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_VERSION,
    FLAW_LEN_CHECK,
    FLAW_CHECKSUM,
    FLAW_END,
    FLAW_TRUNCATE,
    FLAW_HDR_HEX,
    FLAW_CSUM_HEX,
    FLAW_TAIL
  } flaw_t;
  localparam int unsigned FLAW_KINDS = 10;

  // dut ports, all inputs known from time zero
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  ahfc_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ahfc_out_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = CFG_START_CHAR;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // bytes waiting to be offered and statuses waiting to come out
  ahfc_in_t  byte_backlog[$];
  ahfc_out_t status_expected[$];

  // register copy used by both the generator and the frame decoder
  ahfc_cfg_t regs_now = '{START_CHAR_RST, END_CHAR_RST, VERSION_FIRST_RST,
                          VERSION_SECOND_RST};

  // idling knobs, percent of cycles
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  // long receiver hold-off, requested by the stimulus and counted by the stall process
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned mismatches    = 0;
  int unsigned bytes_taken   = 0;
  int unsigned bytes_queued  = 0;
  int unsigned statuses_seen = 0;
  int unsigned by_status [8] = '{default: 0};
  int unsigned cycle_count   = 0;

  // frame decoder state
  logic [POS_W-1:0] fr_pos    = '0;
  logic [SUM_W-1:0] fr_sum    = '0;
  logic [SUM_W-1:0] fr_rx_sum = '0;
  logic [3:0]       fr_nib    = '0;
  logic [7:0]       fr_hdr [6] = '{default: 8'd0};
  status_t          fr_err    = ST_OK;
  logic             fr_closed = 1'b0;

  ascii_hex_frame_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ascii hex digit to nibble, upper and lower case letters both count
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic void frame_clear();
    fr_pos    = '0;
    fr_sum    = '0;
    fr_rx_sum = '0;
    fr_nib    = '0;
    fr_err    = ST_OK;
    fr_closed = 1'b0;
    foreach (fr_hdr[i]) fr_hdr[i] = 8'd0;
  endfunction

  // one byte into the frame decoder, only while the frame is still open and clean
  function automatic void frame_take_byte(input logic [7:0] b);
    logic [3:0]       nib;
    logic             ok;
    logic [7:0]       val;
    logic [3:0]       lchk;
    logic [SUM_W-1:0] neg_sum;
    int unsigned      pos;
    int unsigned      idx;
    int unsigned      dl;
    pos = fr_pos;
    ok  = hex_nibble(b, nib);
    if (pos == 0) begin
      if (b != regs_now.start_char) fr_err = ST_START;
    end else if (pos <= HDR_LAST_POS) begin
      // header chars: summed, decoded in pairs, high nibble first
      fr_sum = fr_sum + SUM_W'(b);
      if (!ok) begin
        fr_err = ST_BAD_HEX;
      end else if (pos % 2 == 1) begin
        fr_nib = nib;
      end else begin
        idx = pos / 2 - 1;
        val = {fr_nib, nib};
        fr_hdr[idx] = val;
        if (idx == HDR_VERSION && val != regs_now.version_first &&
            val != regs_now.version_second) fr_err = ST_VERSION;
        if (idx == HDR_LEN_LO) begin
          // check nibble cancels the three length nibbles mod 16
          lchk = 4'd0 - fr_hdr[4][3:0] - val[7:4] - val[3:0];
          if (fr_hdr[4][7:4] != lchk) fr_err = ST_LEN_CHECK;
        end
      end
    end else begin
      dl = {fr_hdr[4][3:0], fr_hdr[5]};
      if (pos < INFO_POS + dl) begin
        // info chars: any byte, only summed
        fr_sum = fr_sum + SUM_W'(b);
      end else if (pos < CSUM_END_OFS + dl) begin
        if (!ok) begin
          fr_err = ST_BAD_HEX;
        end else begin
          fr_rx_sum = {fr_rx_sum[SUM_W-5:0], nib};
          neg_sum   = SUM_W'(0) - fr_sum;
          if (pos == CSUM_LST_OFS + dl && neg_sum != fr_rx_sum) fr_err = ST_CHECKSUM;
        end
      end else if (b != regs_now.end_char) begin
        fr_err = ST_END;
      end else begin
        fr_closed = 1'b1;
      end
    end
    fr_pos = fr_pos + 1'b1;
  endfunction

  // returns 1 with the predicted status when the item closes its frame
  function automatic logic frame_check_step(input ahfc_in_t item, output ahfc_out_t res);
    res = '0;
    if (!fr_closed && fr_err == ST_OK) frame_take_byte(item.rx_byte);
    if (!item.frame_last) return 1'b0;
    res.status         = (fr_err != ST_OK) ? fr_err : (fr_closed ? ST_OK : ST_TRUNCATED);
    res.device_address = fr_hdr[1];
    res.command_one    = fr_hdr[2];
    res.command_two    = fr_hdr[3];
    res.info_length    = {fr_hdr[4][3:0], fr_hdr[5]};
    frame_clear();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // random case for letters so both spellings get through
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h37 : 8'h57) + 8'(n);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic [3:0] unused_nib;
    do b = 8'($urandom_range(255));
    while (hex_nibble(b, unused_nib));
    return b;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last);
    ahfc_in_t item;
    item.rx_byte    = b;
    item.frame_last = last;
    byte_backlog.push_back(item);
    bytes_queued++;
  endtask

  // builds a frame under the current registers, then damages it as asked
  task automatic queue_frame(input logic [7:0] ver, input logic [7:0] adr,
                             input logic [7:0] c1, input logic [7:0] c2,
                             input int unsigned len, input flaw_t flaw);
    logic [7:0]  fr[$];
    logic [7:0]  hdr [6];
    logic [11:0] ln;
    logic [3:0]  lchk;
    logic [15:0] total;
    logic [15:0] csum;
    int unsigned cut;
    ln   = len[11:0];
    lchk = 4'd0 - ln[11:8] - ln[7:4] - ln[3:0];
    if (flaw == FLAW_LEN_CHECK) lchk = lchk + 4'($urandom_range(1, 15));
    if (flaw == FLAW_VERSION) begin
      do ver = 8'($urandom_range(255));
      while (ver == regs_now.version_first || ver == regs_now.version_second);
    end
    hdr = '{ver, adr, c1, c2, {lchk, ln[11:8]}, ln[7:0]};
    fr.push_back(flaw == FLAW_START ? regs_now.start_char ^ 8'($urandom_range(1, 255))
                                    : regs_now.start_char);
    foreach (hdr[i]) begin
      fr.push_back(hex_char(hdr[i][7:4]));
      fr.push_back(hex_char(hdr[i][3:0]));
    end
    repeat (len) fr.push_back(8'($urandom_range(255)));
    // checksum covers everything after the start char
    total = '0;
    for (int i = 1; i < fr.size(); i++) total = total + 16'(fr[i]);
    csum = 16'd0 - total;
    if (flaw == FLAW_CHECKSUM) csum = csum ^ 16'($urandom_range(1, 65535));
    for (int i = 3; i >= 0; i--) fr.push_back(hex_char(csum[i*4 +: 4]));
    fr.push_back(flaw == FLAW_END ? regs_now.end_char ^ 8'($urandom_range(1, 255))
                                  : regs_now.end_char);
    case (flaw)
      FLAW_HDR_HEX:  fr[$urandom_range(1, 12)] = non_hex_byte();
      FLAW_CSUM_HEX: fr[13 + len + $urandom_range(3)] = non_hex_byte();
      FLAW_TRUNCATE: begin
        // cut early so long declared lengths stay cheap
        cut = $urandom_range(1, (fr.size() - 1 < 40) ? fr.size() - 1 : 40);
        while (fr.size() > cut) void'(fr.pop_back());
      end
      FLAW_TAIL: begin
        // junk after the end char, ignored until the frame's last byte
        repeat ($urandom_range(1, 5)) fr.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    foreach (fr[i]) queue_byte(fr[i], i == fr.size() - 1);
  endtask

  task automatic queue_random_frame();
    flaw_t       flaw;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(99);
    flaw = (pick < 50) ? FLAW_NONE : flaw_t'($urandom_range(1, FLAW_KINDS - 1));
    pick = $urandom_range(99);
    // mostly short frames, a few long ones, and the full length range when truncated
    if (flaw == FLAW_TRUNCATE && pick < 50) len = $urandom_range(4095);
    else if (pick < 85) len = $urandom_range(24);
    else if (pick < 96) len = $urandom_range(25, 120);
    else len = $urandom_range(121, 300);
    queue_frame($urandom_range(1) ? regs_now.version_first : regs_now.version_second,
                8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), len, flaw);
  endtask

  // random bytes, sometimes closing a frame, sometimes running into the next one
  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
  endtask

  // random traffic, always closed by a good frame so the phase ends on a frame boundary
  task automatic fill_random(input int unsigned n);
    int unsigned target;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      if ($urandom_range(99) < 8) queue_noise();
      else queue_random_frame();
    end
    queue_frame(regs_now.version_first, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), $urandom_range(8), FLAW_NONE);
  endtask

  // writes all four registers on back to back edges, block is idle here
  task automatic write_config(input ahfc_cfg_t regs);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_START_CHAR;
    cfg_wdata <= regs.start_char;
    @(posedge clk);
    cfg_addr  <= CFG_END_CHAR;
    cfg_wdata <= regs.end_char;
    @(posedge clk);
    cfg_addr  <= CFG_VERSION_FIRST;
    cfg_wdata <= regs.version_first;
    @(posedge clk);
    cfg_addr  <= CFG_VERSION_SECOND;
    cfg_wdata <= regs.version_second;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    regs_now = regs;
  endtask

  // wait until every byte is in and every status is out, then wait out DRAIN_CYCLES
  task automatic settle();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_valid || status_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input ahfc_cfg_t regs, input int unsigned s_pct,
                           input int unsigned r_pct);
    write_config(regs);
    sender_idle_pct    = s_pct;
    receiver_stall_pct = r_pct;
    fill_random(PHASE_BYTES);
    settle();
  endtask

  // driver: predicts on every accepted byte, then offers the next one
  always @(posedge clk) begin
    ahfc_out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bytes_taken++;
        if (frame_check_step(in_data, res)) status_expected.push_back(res);
      end
      // a held item stays put until taken
      if (!in_valid || !in_stall) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with the long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // monitor: each status item against the oldest prediction
  always @(posedge clk) begin
    ahfc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      statuses_seen++;
      by_status[out_data.status]++;
      if (status_expected.size() == 0) begin
        report_mismatch("status item with none expected", 16'(out_data.status), 16'd0);
      end else begin
        want = status_expected.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 16'(out_data.status), 16'(want.status));
        if (out_data.device_address !== want.device_address)
          report_mismatch("device_address", 16'(out_data.device_address),
                          16'(want.device_address));
        if (out_data.command_one !== want.command_one)
          report_mismatch("command_one", 16'(out_data.command_one), 16'(want.command_one));
        if (out_data.command_two !== want.command_two)
          report_mismatch("command_two", 16'(out_data.command_two), 16'(want.command_two));
        if (out_data.info_length !== want.info_length)
          report_mismatch("info_length", 16'(out_data.info_length), 16'(want.info_length));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset register values: one clean empty frame with extreme header bytes,
    // lone bytes that are not the start char, a frame cut right after its start char,
    // and a bad hex char in the version field
    queue_frame(VERSION_FIRST_RST, 8'h00, 8'hFF, 8'h5A, 0, FLAW_NONE);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(START_CHAR_RST, 1'b1);
    queue_byte(START_CHAR_RST, 1'b0);
    queue_byte(8'h32, 1'b0);
    queue_byte(8'h67, 1'b1);
    settle();

    // register extremes, then random settings, each under its own idle mix
    run_phase(ahfc_cfg_t'{8'h00, 8'hFF, 8'h00, 8'hFF}, 0, 0);
    run_phase(ahfc_cfg_t'{8'hFF, 8'h00, 8'hFF, 8'hFF}, 49, 0);
    run_phase(ahfc_cfg_t'($urandom()), 0, 49);
    run_phase(ahfc_cfg_t'($urandom()), 8, 8);

    // back pressure: the receiver holds off while short frames keep coming,
    // so a second closing byte has to wait on the held status
    write_config(ahfc_cfg_t'{START_CHAR_RST, END_CHAR_RST, VERSION_FIRST_RST,
                             VERSION_SECOND_RST});
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < 8; i++) begin
      queue_byte(START_CHAR_RST, 1'b1);
      queue_frame(VERSION_SECOND_RST, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 0, FLAW_NONE);
    end
    hold_req = hold_req + 1;
    fill_random(PHASE_BYTES - 50);
    settle();

    run_phase(ahfc_cfg_t'($urandom()), 0, 0);

    $display("covered %0d bytes and %0d frame statuses over six register settings",
             bytes_taken, statuses_seen);
    $display("statuses: ok %0d start %0d version %0d length %0d checksum %0d end %0d %s %0d %s %0d",
             by_status[ST_OK], by_status[ST_START], by_status[ST_VERSION],
             by_status[ST_LEN_CHECK], by_status[ST_CHECKSUM], by_status[ST_END],
             "truncated", by_status[ST_TRUNCATED], "bad hex", by_status[ST_BAD_HEX]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ahfc_pkg.sv
hw/rtl/ahfc_in_stage.sv
hw/rtl/ahfc_frame_core.sv
hw/rtl/ahfc_out_stage.sv
hw/rtl/ascii_hex_frame_checker.sv
hw/rtl/ahfc_checker.sv
sim/testbench.sv
